### design/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, constants and types of the frequency-ranked symbol table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int SYM_W           = 16;
  localparam int COUNT_W         = 16;
  localparam int CAP_W           = 5;
  localparam int OCC_W           = 5;
  localparam int DEF_MAX_ENTRIES = 16;

  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(10);
  localparam logic [COUNT_W-1:0] EVICT_LIMIT = COUNT_W'(10000);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  // Search token handed from cell to cell during a scan.
  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] found_count;
    logic               best_ok;
    logic [COUNT_W-1:0] best_count;
    logic [SYM_W-1:0]   best_sym;
  } token_t;

  localparam token_t TOKEN_INIT = '{
    found:       1'b0,
    found_count: '0,
    best_ok:     1'b0,
    best_count:  EVICT_LIMIT,
    best_sym:    '0
  };

  // Per-cell update command, at most one flag set.
  typedef struct packed {
    logic load;
    logic shift;
    logic incr;
  } cell_cmd_t;

endpackage

### design/lfu_recent_symbol_table.sv
// ----------------------------------------------------------------------------
// lfu_recent_symbol_table
// Ordered symbol table with use counts and least-frequently-used eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with symbol_id and initial_count while busy is low; the request
//   is taken at that edge and busy stays high until the result is out.
//   The table is a row of MAX_ENTRIES cells. A search token walks the row one
//   cell per cycle, picking up the first matching entry and the first entry
//   with the smallest count below 10000; then the update state increments,
//   shifts up and appends in all cells at once.
//   busy stays high while the token walks down the cell row and through the
//   update state, so a new request is not taken while one is under way.
//   done is high for one cycle with hit, evicted, evicted_symbol,
//   symbol_count and occupancy; the receiver cannot stall and must take it.
//   The capacity register is written through cfg_valid/cfg_data, always
//   ready; write it only while the block is idle.
//   Reset empties the table and sets capacity to 10. No clearing pass is
//   needed: only occupied cells are ever looked at.
// ----------------------------------------------------------------------------
module lfu_recent_symbol_table #(
  parameter int MAX_ENTRIES = lfu_pkg::DEF_MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lfu_pkg::SYM_W-1:0]    symbol_id,
  input  logic [lfu_pkg::COUNT_W-1:0]  initial_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]    cfg_data,
  output logic                         done,
  output logic                         hit,
  output logic                         evicted,
  output logic [lfu_pkg::SYM_W-1:0]    evicted_symbol,
  output logic [lfu_pkg::COUNT_W-1:0]  symbol_count,
  output logic [lfu_pkg::OCC_W-1:0]    occupancy
);
  import lfu_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int UW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = ((UW > CAP_W) ? UW : CAP_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t             state;
  logic [IW-1:0]      scan_cnt;
  logic [UW-1:0]      used;
  logic [CAP_W-1:0]   capacity;
  logic [SYM_W-1:0]   req_sym;
  logic [COUNT_W-1:0] req_init;

  token_t             tok   [MAX_ENTRIES];
  logic [IW-1:0]      fidx  [MAX_ENTRIES];
  logic [IW-1:0]      bidx  [MAX_ENTRIES];
  logic [SYM_W-1:0]   csym  [MAX_ENTRIES];
  logic [COUNT_W-1:0] ccnt  [MAX_ENTRIES];
  cell_cmd_t          cmd   [MAX_ENTRIES];

  token_t             last;
  logic [IW-1:0]      last_fidx;
  logic [IW-1:0]      last_bidx;
  logic               upd;
  logic               full;
  logic               evict;
  logic               store;
  logic [UW-1:0]      used_mid;
  logic [UW-1:0]      used_next;
  logic [COUNT_W-1:0] hit_count;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign last      = tok[MAX_ENTRIES-1];
  assign last_fidx = fidx[MAX_ENTRIES-1];
  assign last_bidx = bidx[MAX_ENTRIES-1];
  assign upd       = (state == ST_UPDATE);

  always_comb begin
    full      = (CW'(used) + CW'(1)) > CW'(capacity);
    evict     = !last.found && full && last.best_ok;
    used_mid  = used - UW'(evict);
    store     = !last.found && (used_mid < UW'(MAX_ENTRIES));
    used_next = used_mid + UW'(store);
    hit_count = (last.found_count == COUNT_MAX) ? COUNT_MAX
                                                : last.found_count + COUNT_W'(1);
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    token_t             tin;
    logic [IW-1:0]      fin;
    logic [IW-1:0]      bin;
    logic [SYM_W-1:0]   nsym;
    logic [COUNT_W-1:0] ncnt;

    if (i == 0) begin : g_head
      assign tin = TOKEN_INIT;
      assign fin = '0;
      assign bin = '0;
    end else begin : g_body
      assign tin = tok[i-1];
      assign fin = fidx[i-1];
      assign bin = bidx[i-1];
    end

    // the last cell never shifts, its neighbor inputs are idle
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign nsym = '0;
      assign ncnt = '0;
    end else begin : g_link
      assign nsym = csym[i+1];
      assign ncnt = ccnt[i+1];
    end

    always_comb begin
      cmd[i].incr  = upd && last.found && (last_fidx == IW'(i));
      cmd[i].shift = upd && evict && (last_bidx <= IW'(i)) && (UW'(i + 1) < used);
      cmd[i].load  = upd && store && (used_mid == UW'(i));
    end

    lfu_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .occupied  (UW'(i) < used),
      .key       (req_sym),
      .new_count (req_init),
      .tok_in    (tin),
      .fidx_in   (fin),
      .bidx_in   (bin),
      .tok_out   (tok[i]),
      .fidx_out  (fidx[i]),
      .bidx_out  (bidx[i]),
      .cmd       (cmd[i]),
      .nbr_sym   (nsym),
      .nbr_count (ncnt),
      .sym       (csym[i]),
      .count     (ccnt[i])
    );
  end

  // capture request
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_sym  <= symbol_id;
      req_init <= initial_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      used     <= '0;
      capacity <= CAP_RESET;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
          end
        end
        ST_SCAN: begin
          // hold until the token has left the last cell
          if (scan_cnt == IW'(MAX_ENTRIES - 1)) begin
            state <= ST_UPDATE;
          end else begin
            scan_cnt <= scan_cnt + IW'(1);
          end
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
          used  <= used_next;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      hit            <= last.found;
      evicted        <= evict;
      evicted_symbol <= evict ? last.best_sym : '0;
      symbol_count   <= last.found ? hit_count : req_init;
      occupancy      <= OCC_W'(used_next);
    end
  end

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result strobe without an update cycle");

  a_start_to_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(MAX_ENTRIES))
    else $error("occupancy beyond the cell row");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!evicted && occupancy == OCC_W'(used)))
    else $error("hit changed the table size");

  a_evict_shrinks: assert property (@(posedge clk) disable iff (rst)
    upd |=> (CW'(used) <= CW'($past(used)) + CW'(1)))
    else $error("table grew by more than one entry");

endmodule

### design/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// One table entry: holds a symbol and its count, folds itself into the search
// token passed along the row, and takes load, shift-up or increment commands.
// ----------------------------------------------------------------------------
module lfu_cell #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         occupied,
  input  logic [lfu_pkg::SYM_W-1:0]    key,
  input  logic [lfu_pkg::COUNT_W-1:0]  new_count,
  input  lfu_pkg::token_t              tok_in,
  input  logic [IW-1:0]                fidx_in,
  input  logic [IW-1:0]                bidx_in,
  output lfu_pkg::token_t              tok_out,
  output logic [IW-1:0]                fidx_out,
  output logic [IW-1:0]                bidx_out,
  input  lfu_pkg::cell_cmd_t           cmd,
  input  logic [lfu_pkg::SYM_W-1:0]    nbr_sym,
  input  logic [lfu_pkg::COUNT_W-1:0]  nbr_count,
  output logic [lfu_pkg::SYM_W-1:0]    sym,
  output logic [lfu_pkg::COUNT_W-1:0]  count
);
  import lfu_pkg::*;

  token_t      tok_next;
  logic [IW-1:0] fidx_next;
  logic [IW-1:0] bidx_next;

  always_comb begin
    tok_next  = tok_in;
    fidx_next = fidx_in;
    bidx_next = bidx_in;
    // only the first match in order counts
    if (occupied && !tok_in.found && sym == key) begin
      tok_next.found       = 1'b1;
      tok_next.found_count = count;
      fidx_next            = IW'(INDEX);
    end
    // strict compare keeps the earliest of equal minima
    if (occupied && count < tok_in.best_count) begin
      tok_next.best_ok    = 1'b1;
      tok_next.best_count = count;
      tok_next.best_sym   = sym;
      bidx_next           = IW'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    tok_out  <= tok_next;
    fidx_out <= fidx_next;
    bidx_out <= bidx_next;
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      sym   <= key;
      count <= new_count;
    end else if (cmd.shift) begin
      sym   <= nbr_sym;
      count <= nbr_count;
    end else if (cmd.incr) begin
      if (count != COUNT_MAX) begin
        count <= count + COUNT_W'(1);
      end
    end
  end

endmodule
